// ----- hw/rtl/tlef_pkg.sv -----
`default_nettype none
package tlef_pkg;

	localparam int NUMBER_DIGITS_DEF = 10;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int SPACE_RUN = 3;

	localparam logic [7:0] CHAR_SPACE  = 8'd32;
	localparam logic [7:0] CHAR_DOLLAR = 8'd36;
	localparam logic [7:0] CHAR_ZERO   = 8'd48;
	localparam logic [7:0] CHAR_QMARK  = 8'd63;
	localparam logic [7:0] CHAR_I      = 8'd73;
	localparam logic [7:0] CHAR_CARET  = 8'd94;
	localparam logic [7:0] CHAR_TAB    = 8'd9;
	localparam logic [7:0] CHAR_NL     = 8'd10;
	localparam logic [7:0] CHAR_DEL    = 8'd127;
	localparam logic [7:0] CTRL_LIMIT  = 8'd32;
	localparam logic [7:0] CTRL_OFFSET = 8'd64;
	localparam logic [3:0] DIGIT_MAX   = 4'd9;

	typedef enum logic [2:0] {
		REG_NUMBER_MODE      = 3'd0,
		REG_MARK_EOL         = 3'd1,
		REG_FOLD_EMPTY       = 3'd2,
		REG_CARET_TAB        = 3'd3,
		REG_SHOW_NONPRINTING = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEAD,
		ST_DIGIT,
		ST_TRAIL,
		ST_BODY0,
		ST_BODY1
	} emit_st_t;

	typedef struct packed {
		logic clear;
		logic carry;
	} cell_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tlef_digit_cell.sv -----
`default_nettype none
module tlef_digit_cell import tlef_pkg::*; #(
	parameter bit LOW_DIGIT = 1'b0
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctl_t  ctl,
	output logic [3:0]      digit,
	output logic            carry_out,
	output logic            nonzero
);

	logic [3:0] digit_q;
	logic       wrap;

	assign wrap      = (digit_q >= DIGIT_MAX);
	assign carry_out = ctl.carry & wrap;
	assign nonzero   = (digit_q != 4'd0);
	assign digit     = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= {3'd0, LOW_DIGIT};
		end else if (ctl.clear) begin
			digit_q <= {3'd0, LOW_DIGIT};
		end else if (ctl.carry) begin
			digit_q <= wrap ? 4'd0 : digit_q + 4'd1;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/text_line_number_and_escape_filter.sv -----
// Text line numbering and control escaping filter.
// Byte channel (byte_valid/byte_ready): one text byte with a new_file flag per item.
// Run channel (run_valid/run_ready): the output bytes each item causes, one per
// cycle unless run_ready stalls, last_of_run marking the final byte of an item's
// run. A squeezed newline gives no output at all.
// Registers sit on the APB port at 0x00 number_mode, 0x04 mark_eol,
// 0x08 fold_empty, 0x0C caret_tab, 0x10 show_nonprinting; write them while idle.
// The sequencer state register takes an item on acceptance; its first output byte
// then moves into the output register. Throughput: one output byte per cycle
// while run_ready does not stall. A run has 1 or 2 body bytes, plus 6 + the
// number of printed digits when a line number is inserted. The next item is taken
// in the cycle the last byte of the current run moves into the output register.
// The line counter is a row of decimal digit cells passing carry upward; it is
// read most significant digit first and stepped once the number is out.
// Reset clears all registers to zero, the counter to one and line state to
// line start. A stall on the run channel holds the output byte and the run.
`default_nettype none
module text_line_number_and_escape_filter import tlef_pkg::*; #(
	parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	input  wire logic              byte_valid,
	output logic                   byte_ready,
	input  wire logic [7:0]        data_byte,
	input  wire logic              new_file,
	output logic                   run_valid,
	input  wire logic              run_ready,
	output logic      [7:0]        out_byte,
	output logic                   last_of_run
);

	localparam int DW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

	logic [1:0] number_mode_q;
	logic       mark_eol_q;
	logic       fold_empty_q;
	logic       caret_tab_q;
	logic       show_nonprinting_q;
	reg_idx_t   reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_mode_q      <= 2'd0;
			mark_eol_q         <= 1'b0;
			fold_empty_q       <= 1'b0;
			caret_tab_q        <= 1'b0;
			show_nonprinting_q <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_NUMBER_MODE:      number_mode_q      <= pwdata[1:0];
				REG_MARK_EOL:         mark_eol_q         <= pwdata[0];
				REG_FOLD_EMPTY:       fold_empty_q       <= pwdata[0];
				REG_CARET_TAB:        caret_tab_q        <= pwdata[0];
				REG_SHOW_NONPRINTING: show_nonprinting_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_NUMBER_MODE:      prdata[1:0] = number_mode_q;
			REG_MARK_EOL:         prdata[0]   = mark_eol_q;
			REG_FOLD_EMPTY:       prdata[0]   = fold_empty_q;
			REG_CARET_TAB:        prdata[0]   = caret_tab_q;
			REG_SHOW_NONPRINTING: prdata[0]   = show_nonprinting_q;
			default:              prdata      = '0;
		endcase
	end

	// line counter cells
	logic                 inc;
	logic                 accept;
	logic [3:0]           digits  [NUMBER_DIGITS];
	logic [NUMBER_DIGITS-1:0] nonzero;
	logic [NUMBER_DIGITS-1:0] carry;
	cell_ctl_t            ctl [NUMBER_DIGITS];

	genvar gi;
	generate
		for (gi = 0; gi < NUMBER_DIGITS; gi++) begin : g_cell
			if (gi == 0) begin : g_low
				assign ctl[gi] = '{clear: accept & new_file, carry: inc};
			end else begin : g_up
				assign ctl[gi] = '{clear: accept & new_file, carry: carry[gi-1]};
			end
			tlef_digit_cell #(
				.LOW_DIGIT(gi == 0)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl[gi]),
				.digit     (digits[gi]),
				.carry_out (carry[gi]),
				.nonzero   (nonzero[gi])
			);
		end
	endgenerate

	logic [DW-1:0] top;
	always_comb begin
		top = '0;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (nonzero[i]) begin
				top = DW'(i);
			end
		end
	end

	// line state and body bytes
	logic       at_line_start_q;
	logic       prev_empty_q;
	logic       ls;
	logic       pe;
	logic       is_nl;
	logic       squeeze;
	logic       number_it;
	logic [7:0] body0_d;
	logic [7:0] body1_d;
	logic       two_d;
	logic [7:0] body0_q;
	logic [7:0] body1_q;
	logic       two_q;

	assign ls        = new_file | at_line_start_q;
	assign pe        = ~new_file & prev_empty_q;
	assign is_nl     = (data_byte == CHAR_NL);
	assign squeeze   = is_nl & ls & fold_empty_q & pe;
	assign number_it = ls & (number_mode_q[1] ? ~is_nl : number_mode_q[0]);

	always_comb begin
		body0_d = data_byte;
		body1_d = data_byte;
		two_d   = 1'b0;
		if (is_nl) begin
			if (mark_eol_q) begin
				body0_d = CHAR_DOLLAR;
				body1_d = CHAR_NL;
				two_d   = 1'b1;
			end
		end else if (data_byte == CHAR_TAB && caret_tab_q) begin
			body0_d = CHAR_CARET;
			body1_d = CHAR_I;
			two_d   = 1'b1;
		end else if (show_nonprinting_q && data_byte < CTRL_LIMIT && data_byte != CHAR_TAB) begin
			body0_d = CHAR_CARET;
			body1_d = data_byte + CTRL_OFFSET;
			two_d   = 1'b1;
		end else if (show_nonprinting_q && data_byte == CHAR_DEL) begin
			body0_d = CHAR_CARET;
			body1_d = CHAR_QMARK;
			two_d   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_line_start_q <= 1'b1;
			prev_empty_q    <= 1'b0;
		end else if (accept) begin
			if (squeeze) begin
				at_line_start_q <= ls;
				prev_empty_q    <= pe;
			end else if (is_nl) begin
				at_line_start_q <= 1'b1;
				prev_empty_q    <= ls;
			end else begin
				at_line_start_q <= 1'b0;
				prev_empty_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			body0_q <= body0_d;
			body1_q <= body1_d;
			two_q   <= two_d;
		end
	end

	// run sequencer
	emit_st_t      st_q;
	emit_st_t      st_d;
	logic [1:0]    cnt_q;
	logic [1:0]    cnt_d;
	logic [DW-1:0] dig_q;
	logic [DW-1:0] dig_d;
	logic          busy;
	logic          adv;
	logic          last_now;
	logic [7:0]    emit_byte;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;

	assign busy       = (st_q != ST_IDLE);
	assign adv        = busy & (~out_valid_q | run_ready);
	assign last_now   = (st_q == ST_BODY1) | ((st_q == ST_BODY0) & ~two_q);
	assign byte_ready = ~busy | (adv & last_now);
	assign accept     = byte_valid & byte_ready;

	always_comb begin
		st_d      = st_q;
		cnt_d     = cnt_q;
		dig_d     = dig_q;
		inc       = 1'b0;
		emit_byte = CHAR_SPACE;
		unique case (st_q)
			ST_IDLE: ;
			ST_LEAD: begin
				if (adv) begin
					if (cnt_q == 2'(SPACE_RUN - 1)) begin
						st_d  = ST_DIGIT;
						cnt_d = 2'd0;
						dig_d = top;
					end else begin
						cnt_d = cnt_q + 2'd1;
					end
				end
			end
			ST_DIGIT: begin
				emit_byte = CHAR_ZERO + {4'd0, digits[dig_q]};
				if (adv) begin
					if (dig_q == '0) begin
						inc  = 1'b1;
						st_d = ST_TRAIL;
					end else begin
						dig_d = dig_q - DW'(1);
					end
				end
			end
			ST_TRAIL: begin
				if (adv) begin
					if (cnt_q == 2'(SPACE_RUN - 1)) begin
						st_d  = ST_BODY0;
						cnt_d = 2'd0;
					end else begin
						cnt_d = cnt_q + 2'd1;
					end
				end
			end
			ST_BODY0: begin
				emit_byte = body0_q;
				if (adv) begin
					st_d = two_q ? ST_BODY1 : ST_IDLE;
				end
			end
			ST_BODY1: begin
				emit_byte = body1_q;
				if (adv) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
		if (accept) begin
			cnt_d = 2'd0;
			if (squeeze) begin
				st_d = ST_IDLE;
			end else if (number_it) begin
				st_d = ST_LEAD;
			end else begin
				st_d = ST_BODY0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			cnt_q <= 2'd0;
			dig_q <= '0;
		end else begin
			st_q  <= st_d;
			cnt_q <= cnt_d;
			dig_q <= dig_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (run_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= emit_byte;
			out_last_q <= last_now;
		end
	end

	assign run_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = out_last_q;

endmodule
`default_nettype wire

// ----- hw/rtl/tlef_checker.sv -----
`default_nettype none
module tlef_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       pready,
	input wire logic       byte_valid,
	input wire logic       byte_ready,
	input wire logic       run_valid,
	input wire logic       run_ready,
	input wire logic [7:0] out_byte,
	input wire logic       last_of_run
);

	a_run_hold: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && !run_ready |=> run_valid && $stable(out_byte) && $stable(last_of_run))
		else $error("run item changed while stalled");

	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_ready |=> byte_valid)
		else $error("byte item withdrawn");

	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && run_ready && !last_of_run |=> run_valid)
		else $error("gap inside a run");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind text_line_number_and_escape_filter tlef_checker u_tlef_checker (.*);
`default_nettype wire
